// ----- rtl/lpbd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpbd_pkg
// Shared types and character constants for the length-prefixed block deframer.
// ----------------------------------------------------------------------------
package lpbd_pkg;

  // Stream characters
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Width of the maximum block length register
  localparam int unsigned MAX_LEN_BITS = 24;
  localparam logic [MAX_LEN_BITS-1:0] MAX_LEN_RESET = 24'hFF_FFFF;

  typedef enum logic [2:0] {
    PH_LINE_START = 3'd0,
    PH_EMPTY_CR   = 3'd1,
    PH_LEN_DIGITS = 3'd2,
    PH_LEN_REST   = 3'd3,
    PH_PAYLOAD    = 3'd4,
    PH_TERM       = 3'd5,
    PH_TERM_CR    = 3'd6,
    PH_ERROR      = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_NOT_DIGIT = 2'd1,
    ERR_TOO_LONG  = 2'd2,
    ERR_BAD_TERM  = 2'd3
  } err_t;

  // One result item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload;
    logic       first;
    logic       last;
    err_t       code;
  } res_t;

endpackage

// ----- rtl/lpbd_in_reg.sv -----
// ----------------------------------------------------------------------------
// lpbd_in_reg
// Input register: captures one stream byte and holds it until the parser
// takes it.
// ----------------------------------------------------------------------------
module lpbd_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic [7:0] data_r;

  // Hold the byte while the parser cannot take it
  assign in_stall   = valid_r && !take;
  assign byte_valid = valid_r;
  assign byte_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  // Capture on every transfer
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data_r <= in_data_byte;
    end
  end

endmodule

// ----- rtl/lpbd_parser.sv -----
// ----------------------------------------------------------------------------
// lpbd_parser
// Parse state and single-pass next-state logic: length line, payload count,
// terminator check and the sticky error state.
// ----------------------------------------------------------------------------
module lpbd_parser #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic [7:0]                      byte_data,
  input  logic [lpbd_pkg::MAX_LEN_BITS-1:0] max_len,
  output logic                            res_valid,
  output lpbd_pkg::res_t                  res
);

  import lpbd_pkg::*;

  // Accumulator width: count * 10 + digit needs four extra bits
  localparam int unsigned AW = LENGTH_BITS + 4;
  localparam int unsigned CW = (AW > MAX_LEN_BITS) ? AW : MAX_LEN_BITS;

  phase_t                 phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;
  logic                   first_r, first_nxt;

  logic                   is_digit;
  logic [3:0]             digit_val;
  logic [AW-1:0]          base_ext;
  logic [AW-1:0]          acc;
  logic                   too_long;
  logic                   do_digit;
  logic                   do_end;
  logic                   do_fail;
  err_t                   fail_code;

  assign is_digit  = (byte_data >= CH_ZERO) && (byte_data <= CH_NINE);
  assign digit_val = byte_data[3:0];

  // Multiply by ten as shift-and-add; a line start begins from zero
  assign base_ext = (phase_r == PH_LINE_START) ? '0 : {4'b0000, count_r};
  assign acc      = (base_ext << 3) + (base_ext << 1)
                  + {{(AW-4){1'b0}}, digit_val};
  assign too_long = (CW'(acc) > CW'(max_len)) || (acc[AW-1:LENGTH_BITS] != 4'b0000);

  // Next state and result
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    first_nxt = first_r;
    res_valid = 1'b0;
    res       = '{kind: KIND_BYTE, payload: 8'h00, first: 1'b0, last: 1'b0,
                  code: ERR_NONE};
    do_digit  = 1'b0;
    do_end    = 1'b0;
    do_fail   = 1'b0;
    fail_code = ERR_NONE;

    unique case (phase_r)
      PH_LINE_START: begin
        if (byte_data == CH_LF) begin
          res_valid = 1'b1;
          res.kind  = KIND_END;
        end else if (byte_data == CH_CR) begin
          phase_nxt = PH_EMPTY_CR;
        end else if (!is_digit) begin
          do_fail   = 1'b1;
          fail_code = ERR_NOT_DIGIT;
        end else begin
          do_digit = 1'b1;
        end
      end
      PH_EMPTY_CR: begin
        if (byte_data == CH_LF) begin
          phase_nxt = PH_LINE_START;
          res_valid = 1'b1;
          res.kind  = KIND_END;
        end else begin
          do_fail   = 1'b1;
          fail_code = ERR_NOT_DIGIT;
        end
      end
      PH_LEN_DIGITS: begin
        if (is_digit) begin
          do_digit = 1'b1;
        end else if (byte_data == CH_LF) begin
          do_end = 1'b1;
        end else begin
          phase_nxt = PH_LEN_REST;
        end
      end
      PH_LEN_REST: begin
        if (byte_data == CH_LF) begin
          do_end = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        res_valid   = 1'b1;
        res.kind    = KIND_BYTE;
        res.payload = byte_data;
        res.first   = first_r;
        res.last    = (count_r <= LENGTH_BITS'(1));
        first_nxt   = 1'b0;
        if (count_r <= LENGTH_BITS'(1)) begin
          count_nxt = '0;
          phase_nxt = PH_TERM;
        end else begin
          count_nxt = count_r - LENGTH_BITS'(1);
        end
      end
      PH_TERM: begin
        if (byte_data == CH_LF) begin
          phase_nxt = PH_LINE_START;
        end else if (byte_data == CH_CR) begin
          phase_nxt = PH_TERM_CR;
        end else begin
          do_fail   = 1'b1;
          fail_code = ERR_BAD_TERM;
        end
      end
      PH_TERM_CR: begin
        if (byte_data == CH_LF) begin
          phase_nxt = PH_LINE_START;
        end else begin
          do_fail   = 1'b1;
          fail_code = ERR_BAD_TERM;
        end
      end
      PH_ERROR: begin
        // drop everything until reset
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase

    // Accumulate a length digit, flag an oversize length
    if (do_digit) begin
      if (too_long) begin
        do_fail   = 1'b1;
        fail_code = ERR_TOO_LONG;
      end else begin
        count_nxt = acc[LENGTH_BITS-1:0];
        phase_nxt = PH_LEN_DIGITS;
      end
    end

    // End of length line: empty marker or start of payload
    if (do_end) begin
      if (count_r == '0) begin
        phase_nxt = PH_TERM;
        res_valid = 1'b1;
        res.kind  = KIND_EMPTY;
      end else begin
        phase_nxt = PH_PAYLOAD;
        first_nxt = 1'b1;
      end
    end

    // Enter the sticky error state
    if (do_fail) begin
      phase_nxt = PH_ERROR;
      count_nxt = '0;
      first_nxt = 1'b0;
      res_valid = 1'b1;
      res.kind  = KIND_ERROR;
      res.code  = fail_code;
    end
  end

  // Advance the parse state on each byte taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LINE_START;
      count_r <= '0;
      first_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

// ----- rtl/lpbd_out_reg.sv -----
// ----------------------------------------------------------------------------
// lpbd_out_reg
// Result register: holds one result item until the downstream transfer.
// ----------------------------------------------------------------------------
module lpbd_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  lpbd_pkg::res_t res,
  output logic           free,
  output logic           out_valid,
  input  logic           out_stall,
  output lpbd_pkg::res_t out_res
);

  import lpbd_pkg::*;

  logic valid_r;
  res_t res_r;

  // Free when empty or being drained this cycle
  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res;
    end
  end

endmodule

// ----- rtl/length_prefixed_block_deframer.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_block_deframer
// Path: an input transfer goes through the input register, then through the
// parse logic into the result register. Throughput: one byte per cycle while
// the output is not stalled. Reset: synchronous, active low; parser returns
// to line start, maximum block length to all ones.
// ----------------------------------------------------------------------------
module length_prefixed_block_deframer #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload,
  output logic        out_block_first,
  output logic        out_block_last,
  output logic [1:0]  out_error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);

  import lpbd_pkg::*;

  logic                    byte_valid;
  logic [7:0]              byte_data;
  logic                    out_free;
  logic                    step;
  logic                    res_valid;
  res_t                    res;
  res_t                    out_res;
  logic [MAX_LEN_BITS-1:0] max_len_r;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_data;
    end
  end

  // Parse a byte whenever the result register can take its result
  assign step = byte_valid && out_free;

  lpbd_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .take         (out_free),
    .byte_valid   (byte_valid),
    .byte_data    (byte_data)
  );

  lpbd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .byte_data (byte_data),
    .max_len   (max_len_r),
    .res_valid (res_valid),
    .res       (res)
  );

  lpbd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // Unpack the result item onto its ports
  assign out_kind        = out_res.kind;
  assign out_payload     = out_res.payload;
  assign out_block_first = out_res.first;
  assign out_block_last  = out_res.last;
  assign out_error_code  = out_res.code;

endmodule
